/* rtl/xmcr_pkg.sv */
// shared types and constants of the xmodem checksum receiver
`default_nettype none

package xmcr_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 128;
  localparam int unsigned CMD_FIFO_DEPTH    = 2;

  localparam logic [31:0] BASE_ADDR_RST     = 32'h0000_8000;
  localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd4000000;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] BLOCK_FIRST = 8'h01;

  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_JUMP  = 2'd2;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic REG_BASE_ADDR = 1'b0;
  localparam logic REG_TIMEOUT   = 1'b1;

  localparam logic [1:0] OP_NAK   = 2'd0;
  localparam logic [1:0] OP_BURST = 2'd1;
  localparam logic [1:0] OP_EOT   = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [31:0] base_addr;
    logic [31:0] timeout_ticks;
    logic        base_load;
  } cfg_t;

  typedef struct packed {
    logic burst_done;
  } back_status_t;

endpackage

`default_nettype wire

/* rtl/xmcr_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none

module xmcr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* rtl/xmcr_cmd_fifo.sv */
// short command queue between the frame parser and the result sequencer
`default_nettype none

module xmcr_cmd_fifo import xmcr_pkg::*; #(
  parameter int unsigned DEPTH = CMD_FIFO_DEPTH,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      head_o
);

  cmd_t          entry_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/xmcr_front.sv */
// frame parser: checks frame bytes and ticks, fills the payload ram, queues commands
`default_nettype none

module xmcr_front import xmcr_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  localparam int unsigned WORDS   = (PAYLOAD_BYTES + 7) / 8,
  localparam int unsigned WORD_AW = $clog2(WORDS),
  localparam int unsigned POS_W   = $clog2(PAYLOAD_BYTES + 4),
  localparam int unsigned IDX_W   = $clog2(PAYLOAD_BYTES)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               req_type_i,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    push_o,
  output cmd_t                    push_cmd_o,
  input  wire logic               fifo_full_i,
  input  wire back_status_t       status_i,
  output logic                    ram_we_o,
  output logic      [WORD_AW-1:0] ram_waddr_o,
  output logic      [63:0]        ram_wdata_o
);

  logic [POS_W-1:0] frame_pos_q, frame_pos_d;
  logic [7:0]       exp_block_q, exp_block_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       block_q, block_d;
  logic [31:0]      write_addr_q, write_addr_d;
  logic [31:0]      idle_q, idle_d;
  logic             finished_q, finished_d;
  logic             busy_q, busy_d;
  logic [63:0]      word_q, word_d;

  logic             accept, data_phase;
  logic [31:0]      idle_inc;
  logic [POS_W-1:0] idx_full;
  logic [IDX_W-1:0] idx;
  logic [2:0]       lane;
  logic [63:0]      lane_byte;

  assign data_phase = (frame_pos_q >= POS_W'(3)) && (frame_pos_q < POS_W'(PAYLOAD_BYTES + 3));
  assign in_ready_o = !fifo_full_i && !(data_phase && busy_q);
  assign accept     = in_valid_i && in_ready_o;
  assign idle_inc   = idle_q + 32'd1;
  assign idx_full   = frame_pos_q - POS_W'(3);
  assign idx        = idx_full[IDX_W-1:0];
  assign lane       = idx[2:0];
  assign lane_byte  = {56'd0, rx_byte_i} << {lane, 3'b000};

  always_comb begin
    frame_pos_d  = frame_pos_q;
    exp_block_d  = exp_block_q;
    sum_d        = sum_q;
    block_d      = block_q;
    write_addr_d = write_addr_q;
    idle_d       = idle_q;
    finished_d   = finished_q;
    busy_d       = busy_q && !status_i.burst_done;
    word_d       = ((lane == 3'd0) ? 64'd0 : word_q) | lane_byte;
    push_o       = 1'b0;
    push_cmd_o   = '{op: OP_NAK, addr: 32'd0};
    ram_we_o     = 1'b0;
    ram_waddr_o  = WORD_AW'(idx >> 3);
    ram_wdata_o  = word_d;

    if (cfg_i.base_load) begin
      write_addr_d = cfg_i.base_addr;
    end

    if (accept && !finished_q) begin
      if (req_type_i == REQ_TICK) begin
        if (idle_inc >= cfg_i.timeout_ticks) begin
          idle_d = idle_inc - cfg_i.timeout_ticks;
          push_o = 1'b1;
        end else begin
          idle_d = idle_inc;
        end
      end else begin
        idle_d = '0;
        if (frame_pos_q == POS_W'(0)) begin
          if (rx_byte_i == CH_EOT) begin
            push_o     = 1'b1;
            push_cmd_o = '{op: OP_EOT, addr: cfg_i.base_addr};
            finished_d = 1'b1;
          end else if (rx_byte_i == CH_SOH) begin
            sum_d       = rx_byte_i;
            frame_pos_d = POS_W'(1);
          end else begin
            push_o = 1'b1;
          end
        end else if (frame_pos_q == POS_W'(1)) begin
          if (rx_byte_i == exp_block_q) begin
            sum_d       = sum_q + rx_byte_i;
            block_d     = rx_byte_i;
            frame_pos_d = POS_W'(2);
          end else begin
            frame_pos_d = '0;
            push_o      = 1'b1;
          end
        end else if (frame_pos_q == POS_W'(2)) begin
          if (rx_byte_i == ~block_q) begin
            sum_d       = sum_q + rx_byte_i;
            frame_pos_d = POS_W'(3);
          end else begin
            frame_pos_d = '0;
            push_o      = 1'b1;
          end
        end else if (data_phase) begin
          sum_d       = sum_q + rx_byte_i;
          frame_pos_d = frame_pos_q + POS_W'(1);
          ram_we_o    = (lane == 3'd7) || (idx == IDX_W'(PAYLOAD_BYTES - 1));
        end else begin
          frame_pos_d = '0;
          push_o      = 1'b1;
          if (rx_byte_i == sum_q) begin
            push_cmd_o   = '{op: OP_BURST, addr: write_addr_q};
            write_addr_d = write_addr_q + 32'(PAYLOAD_BYTES);
            exp_block_d  = exp_block_q + 8'd1;
            busy_d       = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pos_q  <= '0;
      exp_block_q  <= BLOCK_FIRST;
      sum_q        <= '0;
      block_q      <= '0;
      write_addr_q <= BASE_ADDR_RST;
      idle_q       <= '0;
      finished_q   <= 1'b0;
      busy_q       <= 1'b0;
    end else begin
      frame_pos_q  <= frame_pos_d;
      exp_block_q  <= exp_block_d;
      sum_q        <= sum_d;
      block_q      <= block_d;
      write_addr_q <= write_addr_d;
      idle_q       <= idle_d;
      finished_q   <= finished_d;
      busy_q       <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !finished_q && req_type_i == REQ_BYTE && data_phase) begin
      word_q <= word_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/xmcr_back.sv */
// result sequencer: turns queued commands into transmit, write and jump results
`default_nettype none

module xmcr_back import xmcr_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  localparam int unsigned WORDS   = (PAYLOAD_BYTES + 7) / 8,
  localparam int unsigned WORD_AW = $clog2(WORDS)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fifo_empty_i,
  input  wire cmd_t               head_i,
  output logic                    pop_o,
  output back_status_t            status_o,
  output logic                    ram_re_o,
  output logic      [WORD_AW-1:0] ram_raddr_o,
  input  wire logic [63:0]        ram_rdata_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [1:0]         kind_o,
  output logic      [7:0]         tx_byte_o,
  output logic      [31:0]        addr_o,
  output logic      [63:0]        data_o,
  output logic                    last_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_TX      = 3'd1;
  localparam logic [2:0] ST_RD      = 3'd2;
  localparam logic [2:0] ST_WR      = 3'd3;
  localparam logic [2:0] ST_ACK     = 3'd4;
  localparam logic [2:0] ST_EOT_ACK = 3'd5;
  localparam logic [2:0] ST_JUMP    = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [WORD_AW-1:0] word_q, word_d;
  logic [31:0]        addr_q, addr_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         kind_q, kind_d;
  logic [7:0]         tx_q, tx_d;
  logic [31:0]        oaddr_q, oaddr_d;
  logic [63:0]        data_q, data_d;
  logic               last_q, last_d;
  logic               out_free, load;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    word_d      = word_q;
    addr_d      = addr_q;
    load        = 1'b0;
    kind_d      = KIND_TX;
    tx_d        = 8'd0;
    oaddr_d     = 32'd0;
    data_d      = 64'd0;
    last_d      = 1'b0;
    pop_o       = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = word_q;
    status_o    = '{burst_done: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o  = 1'b1;
          addr_d = head_i.addr;
          word_d = '0;
          unique case (head_i.op)
            OP_NAK:   state_d = ST_TX;
            OP_BURST: state_d = ST_RD;
            OP_EOT:   state_d = ST_EOT_ACK;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_TX: begin
        if (out_free) begin
          load    = 1'b1;
          tx_d    = CH_NAK;
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RD: begin
        ram_re_o = 1'b1;
        state_d  = ST_WR;
      end
      ST_WR: begin
        if (out_free) begin
          load    = 1'b1;
          kind_d  = KIND_WRITE;
          oaddr_d = addr_q;
          data_d  = ram_rdata_i;
          addr_d  = addr_q + 32'd8;
          if (word_q == WORD_AW'(WORDS - 1)) begin
            state_d = ST_ACK;
          end else begin
            word_d  = word_q + WORD_AW'(1);
            state_d = ST_RD;
          end
        end
      end
      ST_ACK: begin
        if (out_free) begin
          load     = 1'b1;
          tx_d     = CH_ACK;
          last_d   = 1'b1;
          status_o = '{burst_done: 1'b1};
          state_d  = ST_IDLE;
        end
      end
      ST_EOT_ACK: begin
        if (out_free) begin
          load    = 1'b1;
          tx_d    = CH_ACK;
          state_d = ST_JUMP;
        end
      end
      ST_JUMP: begin
        if (out_free) begin
          load    = 1'b1;
          kind_d  = KIND_JUMP;
          oaddr_d = addr_q;
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = load ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    addr_q <= addr_d;
    if (load) begin
      kind_q  <= kind_d;
      tx_q    <= tx_d;
      oaddr_q <= oaddr_d;
      data_q  <= data_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign tx_byte_o   = tx_q;
  assign addr_o      = oaddr_q;
  assign data_o      = data_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

/* rtl/xmodem_checksum_receiver_core.sv */
// top level of the xmodem checksum receiver with its register port
// a nak passes the command queue, the sequencer state and the output register; the first write also the ram read
// throughput: one input transaction per cycle while the command queue has room and no write burst holds payload bytes
// a good frame gives WORDS writes, each through a ram read and then the output register, then ack
// payload bytes of the next frame wait until that write burst has finished
// reset: asynchronous, clears control state and registers; the payload ram is not cleared
`default_nettype none

module xmodem_checksum_receiver_core import xmcr_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  localparam int unsigned WORDS   = (PAYLOAD_BYTES + 7) / 8,
  localparam int unsigned WORD_AW = $clog2(WORDS)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [1:0]  kind_o,
  output logic      [7:0]  tx_byte_o,
  output logic      [31:0] addr_o,
  output logic      [63:0] data_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [31:0]        base_addr_q, base_addr_d;
  logic [31:0]        timeout_q, timeout_d;
  logic               base_load_d;
  logic               cfg_wr;
  cfg_t               cfg;
  logic               push, fifo_full, pop, fifo_empty;
  cmd_t               push_cmd, head;
  back_status_t       status;
  logic               ram_we, ram_re;
  logic [WORD_AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]        ram_wdata, ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    base_addr_d = base_addr_q;
    timeout_d   = timeout_q;
    base_load_d = 1'b0;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_BASE_ADDR: begin
          base_addr_d = pwdata;
          base_load_d = 1'b1;
        end
        REG_TIMEOUT: timeout_d = pwdata;
        default: ;
      endcase
    end
    unique case (paddr[2])
      REG_BASE_ADDR: prdata = base_addr_q;
      REG_TIMEOUT:   prdata = timeout_q;
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_addr_q <= BASE_ADDR_RST;
      timeout_q   <= TIMEOUT_TICKS_RST;
    end else begin
      base_addr_q <= base_addr_d;
      timeout_q   <= timeout_d;
    end
  end

  assign cfg = '{base_addr: base_addr_d, timeout_ticks: timeout_q, base_load: base_load_d};

  xmcr_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .rx_byte_i   (rx_byte_i),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .fifo_full_i (fifo_full),
    .status_i    (status),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  xmcr_cmd_fifo #(.DEPTH(CMD_FIFO_DEPTH)) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .empty_o    (fifo_empty),
    .head_o     (head)
  );

  xmcr_ram #(.WIDTH(64), .DEPTH(WORDS)) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  xmcr_back #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .head_i       (head),
    .pop_o        (pop),
    .status_o     (status),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .tx_byte_o    (tx_byte_o),
    .addr_o       (addr_o),
    .data_o       (data_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

/* rtl/xmcr_checker.sv */
// port-level assertions for the xmodem checksum receiver and their bind
`default_nettype none

module xmcr_checker import xmcr_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  kind_o,
  input wire logic [7:0]  tx_byte_o,
  input wire logic [31:0] addr_o,
  input wire logic [63:0] data_o,
  input wire logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(tx_byte_o)
      && $stable(addr_o) && $stable(data_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_TX |->
      (tx_byte_o == CH_ACK || tx_byte_o == CH_NAK) && addr_o == 32'd0 && data_o == 64'd0)
    else $error("bad transmit result");

  a_jump_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_JUMP |-> last_o && data_o == 64'd0 && tx_byte_o == 8'd0)
    else $error("jump not final or not clean");

  a_write_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_WRITE |-> !last_o && tx_byte_o == 8'd0)
    else $error("memory write marked final");

  a_nak_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_TX && tx_byte_o == CH_NAK |-> last_o)
    else $error("nak not final");

endmodule

bind xmodem_checksum_receiver_core xmcr_checker u_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench of the xmodem checksum receiver core
`timescale 1ns / 1ps

module testbench;
  import xmcr_pkg::*;

  localparam int unsigned NBYTES = PAYLOAD_BYTES_DEF;
  localparam int unsigned NWORDS = (NBYTES + 7) / 8;
  localparam int unsigned SETTLE = 8;
  localparam logic [2:0] ADDR_BASE = {REG_BASE_ADDR, 2'b00};
  localparam logic [2:0] ADDR_TIMEOUT = {REG_TIMEOUT, 2'b00};
  localparam logic [31:0] FILL_RANDOM = 32'h100;
  localparam int unsigned NROWS = 30;

  typedef enum logic [2:0] {
    ACT_BYTE, ACT_TICK, ACT_BODY, ACT_SUM, ACT_BASE, ACT_TIMEOUT
  } act_e;

  typedef enum logic [1:0] {PIN_PRED, PIN_NONE, PIN_NAK} pin_e;

  typedef enum logic [2:0] {
    FLAW_NONE, FLAW_BLOCK, FLAW_REPEAT, FLAW_COMP, FLAW_SUM
  } flaw_e;

  typedef struct packed {
    act_e        act;
    logic [31:0] arg;
    pin_e        pin;
  } row_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [31:0] addr;
    logic [63:0] data;
    logic        last;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        req_type_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  tx_byte_o;
  logic [31:0] addr_o;
  logic [63:0] data_o;
  logic        last_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  xmodem_checksum_receiver_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .tx_byte_o   (tx_byte_o),
    .addr_o      (addr_o),
    .data_o      (data_o),
    .last_o      (last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // receiver shadow state
  logic [31:0] reg_base;
  logic [31:0] reg_timeout;
  logic [7:0]  rx_pos;
  logic [7:0]  want_block;
  logic [7:0]  rx_sum;
  logic [7:0]  rx_block;
  logic [7:0]  rx_payload [NBYTES];
  logic [31:0] load_addr;
  logic [31:0] idle_ticks;
  logic        rx_done;

  reply_t step_replies [$];
  reply_t due_replies [$];
  reply_t seen_reply;
  reply_t due_reply;
  row_t   plan [NROWS];

  bit src_idle;
  bit sink_idle;
  int stall_left;
  int errors;
  int n_items;
  int n_pred;
  int n_checked;
  int n_frames;
  int n_cfg;
  int r;
  int k;
  int ph;
  int ph_items;
  int ph_results;
  int guard;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function automatic reply_t reply_of(logic [1:0] kd, logic [7:0] tx, logic [31:0] a,
                                      logic [63:0] d, logic l);
    reply_t rp;
    rp.kind = kd;
    rp.tx_byte = tx;
    rp.addr = a;
    rp.data = d;
    rp.last = l;
    return rp;
  endfunction

  function automatic void emit(logic [1:0] kd, logic [7:0] tx, logic [31:0] a, logic [63:0] d);
    step_replies.push_back(reply_of(kd, tx, a, d, 1'b0));
  endfunction

  function automatic void set_register(logic [2:0] a, logic [31:0] v);
    if (a == ADDR_BASE) begin
      reg_base = v;
      load_addr = v;
    end else if (a == ADDR_TIMEOUT) begin
      reg_timeout = v;
    end
  endfunction

  function automatic void advance_receiver(logic req, logic [7:0] b);
    logic [63:0] word;
    int w;
    int i;
    step_replies.delete();
    if (rx_done) return;
    if (req == REQ_TICK) begin
      idle_ticks = idle_ticks + 32'd1;
      if (idle_ticks >= reg_timeout) begin
        idle_ticks = idle_ticks - reg_timeout;
        emit(KIND_TX, CH_NAK, '0, '0);
      end
    end else begin
      idle_ticks = '0;
      if (rx_pos == 8'd0) begin
        if (b == CH_EOT) begin
          emit(KIND_TX, CH_ACK, '0, '0);
          emit(KIND_JUMP, '0, reg_base, '0);
          rx_done = 1'b1;
        end else if (b == CH_SOH) begin
          rx_sum = b;
          rx_pos = 8'd1;
        end else begin
          emit(KIND_TX, CH_NAK, '0, '0);
        end
      end else if (rx_pos == 8'd1) begin
        if (b == want_block) begin
          rx_sum = rx_sum + b;
          rx_block = b;
          rx_pos = 8'd2;
        end else begin
          rx_pos = 8'd0;
          emit(KIND_TX, CH_NAK, '0, '0);
        end
      end else if (rx_pos == 8'd2) begin
        if (b == 8'hFF - rx_block) begin
          rx_sum = rx_sum + b;
          rx_pos = 8'd3;
        end else begin
          rx_pos = 8'd0;
          emit(KIND_TX, CH_NAK, '0, '0);
        end
      end else if (rx_pos < NBYTES + 3) begin
        rx_payload[rx_pos - 8'd3] = b;
        rx_sum = rx_sum + b;
        rx_pos = rx_pos + 8'd1;
      end else begin
        if (b == rx_sum) begin
          for (w = 0; w < NWORDS; w++) begin
            word = '0;
            for (i = 0; i < 8; i++) begin
              if (w * 8 + i < NBYTES) word[8*i +: 8] = rx_payload[w * 8 + i];
            end
            emit(KIND_WRITE, '0, load_addr, word);
            load_addr = load_addr + 32'd8;
          end
          load_addr = load_addr - 32'(NWORDS * 8) + 32'(NBYTES);
          emit(KIND_TX, CH_ACK, '0, '0);
          want_block = want_block + 8'd1;
          n_frames++;
        end else begin
          emit(KIND_TX, CH_NAK, '0, '0);
        end
        rx_pos = 8'd0;
      end
    end
    if (step_replies.size() != 0) step_replies[step_replies.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] rnd_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_item(logic req, logic [7:0] b, pin_e pin);
    in_valid_i <= 1'b1;
    req_type_i <= req;
    rx_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    advance_receiver(req, b);
    n_items++;
    case (pin)
      PIN_PRED: begin
        foreach (step_replies[j]) due_replies.push_back(step_replies[j]);
        n_pred += step_replies.size();
      end
      PIN_NAK: begin
        due_replies.push_back(reply_of(KIND_TX, CH_NAK, '0, '0, 1'b1));
        n_pred++;
      end
      default: ;
    endcase
    if (src_idle && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] a, logic [31:0] v);
    wait_quiet();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    set_register(a, v);
    n_cfg++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== v) begin
      flag_error($sformatf("register %0h read back %08h, written %08h", a, prdata, v));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic feed(logic [7:0] b);
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 3)) push_item(REQ_TICK, 8'($urandom), PIN_PRED);
    end
    push_item(REQ_BYTE, b, PIN_PRED);
  endtask

  task automatic close_frame();
    while (rx_pos != 8'd0) begin
      if (rx_pos == 8'd1) push_item(REQ_BYTE, want_block + 8'd1, PIN_PRED);
      else if (rx_pos == 8'd2) push_item(REQ_BYTE, rx_block, PIN_PRED);
      else push_item(REQ_BYTE, rx_sum + 8'd1, PIN_PRED);
    end
  endtask

  task automatic send_frame(flaw_e flaw);
    logic [7:0] blk_b;
    logic [7:0] comp_b;
    int n;
    close_frame();
    feed(CH_SOH);
    blk_b = want_block;
    if (flaw == FLAW_BLOCK) blk_b = want_block + 8'($urandom_range(1, 255));
    if (flaw == FLAW_REPEAT) blk_b = want_block - 8'd1;
    feed(blk_b);
    if (flaw == FLAW_BLOCK || flaw == FLAW_REPEAT) return;
    comp_b = 8'hFF - blk_b;
    if (flaw == FLAW_COMP) comp_b = comp_b + 8'($urandom_range(1, 255));
    feed(comp_b);
    if (flaw == FLAW_COMP) return;
    for (n = 0; n < NBYTES; n++) feed(rnd_byte());
    feed(rx_sum + (flaw == FLAW_SUM ? 8'($urandom_range(1, 255)) : 8'd0));
  endtask

  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 2) == 0) begin
        push_item(REQ_TICK, 8'($urandom), PIN_PRED);
      end else begin
        b = rnd_byte();
        if (rx_pos == 8'd0 && b == CH_EOT) b = CH_NAK;
        push_item(REQ_BYTE, b, PIN_PRED);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (sink_idle && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_reply = reply_of(kind_o, tx_byte_o, addr_o, data_o, last_o);
      if (due_replies.size() == 0) begin
        flag_error($sformatf("unexpected result: kind %0d tx %02h addr %08h data %016h last %0b",
                             seen_reply.kind, seen_reply.tx_byte, seen_reply.addr,
                             seen_reply.data, seen_reply.last));
      end else begin
        due_reply = due_replies.pop_front();
        n_checked++;
        if (seen_reply !== due_reply) begin
          flag_error($sformatf(
            "mismatch: want kind %0d tx %02h addr %08h data %016h last %0b, got %0d %02h %08h %016h %0b",
            due_reply.kind, due_reply.tx_byte, due_reply.addr, due_reply.data, due_reply.last,
            seen_reply.kind, seen_reply.tx_byte, seen_reply.addr, seen_reply.data,
            seen_reply.last));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = REQ_BYTE;
    rx_byte_i = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    stall_left = 0;
    reg_base = BASE_ADDR_RST;
    reg_timeout = TIMEOUT_TICKS_RST;
    rx_pos = 8'd0;
    want_block = BLOCK_FIRST;
    rx_sum = 8'd0;
    rx_block = 8'd0;
    load_addr = BASE_ADDR_RST;
    idle_ticks = '0;
    rx_done = 1'b0;

    plan = '{
      '{ACT_BYTE,    32'h00,        PIN_NAK},
      '{ACT_BYTE,    32'hFF,        PIN_NAK},
      '{ACT_TICK,    32'h0,         PIN_NONE},
      '{ACT_BYTE,    32'(CH_SOH),   PIN_NONE},
      '{ACT_BYTE,    32'h02,        PIN_NAK},
      '{ACT_BYTE,    32'(CH_SOH),   PIN_NONE},
      '{ACT_BYTE,    32'h01,        PIN_NONE},
      '{ACT_BYTE,    32'h00,        PIN_NAK},
      '{ACT_BYTE,    32'(CH_SOH),   PIN_NONE},
      '{ACT_BYTE,    32'h01,        PIN_NONE},
      '{ACT_BYTE,    32'hFE,        PIN_NONE},
      '{ACT_BODY,    32'hFF,        PIN_NONE},
      '{ACT_SUM,     32'h01,        PIN_NAK},
      '{ACT_BASE,    32'hFFFF_FFF8, PIN_NONE},
      '{ACT_TIMEOUT, 32'd1,         PIN_NONE},
      '{ACT_TICK,    32'h0,         PIN_NAK},
      '{ACT_TICK,    32'h0,         PIN_NAK},
      '{ACT_BYTE,    32'(CH_SOH),   PIN_NONE},
      '{ACT_BYTE,    32'h01,        PIN_NONE},
      '{ACT_BYTE,    32'hFE,        PIN_NONE},
      '{ACT_BODY,    FILL_RANDOM,   PIN_NONE},
      '{ACT_TICK,    32'h0,         PIN_NAK},
      '{ACT_SUM,     32'h00,        PIN_PRED},
      '{ACT_BYTE,    32'(CH_SOH),   PIN_NONE},
      '{ACT_BYTE,    32'h01,        PIN_NAK},
      '{ACT_TIMEOUT, 32'd0,         PIN_NONE},
      '{ACT_TICK,    32'h0,         PIN_NAK},
      '{ACT_TICK,    32'h0,         PIN_NAK},
      '{ACT_TIMEOUT, 32'hFFFF_FFFF, PIN_NONE},
      '{ACT_TICK,    32'h0,         PIN_NONE}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < NROWS; r++) begin
      case (plan[r].act)
        ACT_BYTE: push_item(REQ_BYTE, plan[r].arg[7:0], plan[r].pin);
        ACT_TICK: push_item(REQ_TICK, 8'($urandom), plan[r].pin);
        ACT_BODY: begin
          for (k = 0; k < NBYTES; k++) begin
            push_item(REQ_BYTE, plan[r].arg[8] ? rnd_byte() : plan[r].arg[7:0], plan[r].pin);
          end
        end
        ACT_SUM: push_item(REQ_BYTE, rx_sum + plan[r].arg[7:0], plan[r].pin);
        ACT_BASE: write_reg(ADDR_BASE, plan[r].arg);
        ACT_TIMEOUT: write_reg(ADDR_TIMEOUT, plan[r].arg);
        default: ;
      endcase
    end

    // broken frame headers and line noise; the last phase runs without idling
    for (ph = 0; ph < 3; ph++) begin
      write_reg(ADDR_BASE, ph == 0 ? 32'h0 : $urandom);
      write_reg(ADDR_TIMEOUT, $urandom_range(1, 5));
      src_idle = (ph < 2);
      sink_idle = (ph < 2);
      ph_items = n_items;
      ph_results = n_pred;
      while (n_items - ph_items < 10 || n_pred - ph_results < 4) begin
        case ($urandom_range(0, 4))
          0: send_frame(FLAW_BLOCK);
          1: send_frame(FLAW_REPEAT);
          2: send_frame(FLAW_COMP);
          default: send_noise();
        endcase
      end
    end

    // end of transfer, then traffic that must be ignored
    close_frame();
    push_item(REQ_BYTE, CH_EOT, PIN_PRED);
    push_item(REQ_BYTE, CH_SOH, PIN_PRED);
    push_item(REQ_TICK, 8'($urandom), PIN_PRED);
    push_item(REQ_BYTE, CH_EOT, PIN_PRED);
    in_valid_i <= 1'b0;

    guard = 0;
    while (due_replies.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
    if (due_replies.size() != 0) begin
      flag_error($sformatf("%0d expected results never arrived", due_replies.size()));
      errors += due_replies.size() - 1;
    end

    $display("summary: %0d input transactions, %0d results checked, %0d frames acked, %0d register writes",
             n_items, n_checked, n_frames, n_cfg);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* xmodem_checksum_receiver_core.f */
rtl/xmcr_pkg.sv
rtl/xmcr_ram.sv
rtl/xmcr_cmd_fifo.sv
rtl/xmcr_front.sv
rtl/xmcr_back.sv
rtl/xmodem_checksum_receiver_core.sv
rtl/xmcr_checker.sv
tb/testbench.sv
